// ===== src/two_axis_line_stepper_defines.svh =====
// Assertion macros shared by the two-axis line stepper RTL.
`ifndef TWO_AXIS_LINE_STEPPER_DEFINES_SVH
`define TWO_AXIS_LINE_STEPPER_DEFINES_SVH
`ifndef SYNTHESIS
`define TALS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("two_axis_line_stepper assertion failed");
`define TALS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("two_axis_line_stepper assertion failed");
`else
`define TALS_ASSERT(lbl, clk, rst_n, prop)
`define TALS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/tals_pkg.sv =====
// Shared types and constants of the two-axis line stepper.
package tals_pkg;

  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_Y = 2'd3;

  localparam logic [15:0] RST_STEPS_X  = 16'd10000;
  localparam logic [15:0] RST_STEPS_Y  = 16'd10000;
  localparam logic [15:0] RST_TRAVEL_X = 16'd30000;
  localparam logic [15:0] RST_TRAVEL_Y = 16'd35000;

  localparam int PROD_W = 32;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 5;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic        is_tick;
    logic [15:0] target_x;
    logic [15:0] target_y;
    logic [7:0]  pen;
    logic [15:0] interval;
  } cmd_t;

endpackage

// ===== src/tals_ifs.sv =====
// Valid/ready channel interfaces for the stepper's input and result items.
interface tals_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] target_x;
  logic [15:0] target_y;
  logic [7:0]  pen_setting;
  logic [15:0] interval_ticks;

  modport source (output valid, op, target_x, target_y, pen_setting, interval_ticks,
                  input ready);
  modport sink (input valid, op, target_x, target_y, pen_setting, interval_ticks,
                output ready);
endinterface

interface tals_out_if;
  logic        valid;
  logic        ready;
  logic        step_x;
  logic        step_y;
  logic        dir_x;
  logic        dir_y;
  logic [7:0]  pen_out;
  logic        busy_res;
  logic        done_res;
  logic        rejected;
  logic [15:0] pos_x;
  logic [15:0] pos_y;

  modport source (output valid, step_x, step_y, dir_x, dir_y, pen_out, busy_res,
                  done_res, rejected, pos_x, pos_y, input ready);
  modport sink (input valid, step_x, step_y, dir_x, dir_y, pen_out, busy_res,
                done_res, rejected, pos_x, pos_y, output ready);
endinterface

// ===== src/tals_front.sv =====
// Front end: accepts input items, classifies them and hands commands to the queue.
module tals_front (
  input  logic          clk,
  input  logic          rst_n,
  tals_in_if.sink       in_ch,
  output logic          push_valid,
  output tals_pkg::cmd_t push_cmd,
  input  logic          push_ready
);
  import tals_pkg::*;

  logic fr_valid_r;
  cmd_t fr_cmd_r;
  cmd_t cmd_nxt;

  assign in_ch.ready = !fr_valid_r || push_ready;
  assign push_valid  = fr_valid_r;
  assign push_cmd    = fr_cmd_r;

  always_comb begin
    cmd_nxt.is_tick  = (in_ch.op == OP_TICK);
    cmd_nxt.target_x = in_ch.target_x;
    cmd_nxt.target_y = in_ch.target_y;
    cmd_nxt.pen      = in_ch.pen_setting;
    cmd_nxt.interval = (in_ch.interval_ticks == 16'd0) ? 16'd1 : in_ch.interval_ticks;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      fr_valid_r <= 1'b1;
    end else if (push_ready) begin
      fr_valid_r <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      fr_cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== src/tals_queue.sv =====
// Two-entry command queue between the front end and the execution back end.
`include "two_axis_line_stepper_defines.svh"
module tals_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  tals_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output tals_pkg::cmd_t pop_cmd,
  input  logic           pop_ready
);
  import tals_pkg::*;

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = q_mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_cmd;
    end
  end

  `TALS_ASSERT(a_q_count_bound, clk, rst_n, count_r <= QCNT_W'(QDEPTH))

endmodule

// ===== src/tals_back.sv =====
// Back end: scales move targets with a serial divider and runs the line phases on ticks.
`include "two_axis_line_stepper_defines.svh"
module tals_back #(
  parameter int POS_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  tals_pkg::cmd_t                 q_cmd,
  output logic                           q_pop,
  input  logic                           cfg_we,
  input  logic [tals_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tals_pkg::CFG_DATA_W-1:0] cfg_wdata,
  tals_out_if.source                     out_ch
);
  import tals_pkg::*;

  localparam int EW = POS_BITS + 3;
  localparam int CW = POS_BITS + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN} st_t;

  st_t st_r;
  logic [15:0] steps_x_r, steps_y_r, travel_x_r, travel_y_r;

  logic [POS_BITS-1:0] pos_x_r, pos_y_r, dist_x_r, dist_y_r, nx_r, ny_r;
  logic signed [EW-1:0] err_r;
  logic [CW-1:0] cov_x_r, cov_y_r;
  logic pend_x_r, pend_y_r, run_r;
  logic [1:0] dir_r;
  logic [15:0] tick_cnt_r, tick_per_r;
  logic [7:0] pen_r;

  logic out_valid_r, sx_r, sy_r, done_r, rej_r;

  logic [15:0] tgt_x_r, tgt_y_r;
  logic axis_y_r;
  logic [PROD_W-1:0] dvd_r, quo_r;
  logic [16:0] rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic [15:0] mul_a, mul_b, divisor;
  logic [PROD_W-1:0] product;
  logic [16:0] rem_sh, rem_nxt;
  logic rem_ge;
  logic [PROD_W-1:0] quo_nxt;
  logic sat;
  logic [POS_BITS-1:0] scaled;

  logic [16:0] cnt_inc;
  logic expire;
  logic signed [EW:0] e2, dx_s, dyn_s, err_sum;
  logic y_dec, x_dec, complete;
  logic [POS_BITS-1:0] dist_x_nxt, dist_y_nxt;
  logic [1:0] dir_nxt;
  logic [PROD_W-1:0] pos_x_w, pos_y_w;

  assign q_pop = q_valid && (st_r == ST_IDLE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    mul_a   = axis_y_r ? tgt_y_r : tgt_x_r;
    mul_b   = axis_y_r ? steps_y_r : steps_x_r;
    divisor = axis_y_r ? travel_y_r : travel_x_r;
    product = PROD_W'(mul_a) * PROD_W'(mul_b);
    rem_sh  = {rem_r[15:0], dvd_r[PROD_W-1]};
    rem_ge  = rem_sh >= {1'b0, divisor};
    rem_nxt = rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
    quo_nxt = {quo_r[PROD_W-2:0], rem_ge};
    sat     = (divisor == 16'd0) || ((quo_nxt >> POS_BITS) != '0);
    scaled  = sat ? {POS_BITS{1'b1}} : quo_nxt[POS_BITS-1:0];
  end

  always_comb begin
    cnt_inc  = {1'b0, tick_cnt_r} + 17'd1;
    expire   = cnt_inc >= {1'b0, tick_per_r};
    e2       = {err_r, 1'b0};
    dx_s     = $signed({{(EW + 1 - POS_BITS){1'b0}}, dist_x_r});
    dyn_s    = -$signed({{(EW + 1 - POS_BITS){1'b0}}, dist_y_r});
    y_dec    = e2 <= dx_s;
    x_dec    = e2 >= dyn_s;
    err_sum  = {err_r[EW-1], err_r} + (y_dec ? dx_s : '0) + (x_dec ? dyn_s : '0);
    complete = (cov_x_r >= {1'b0, dist_x_r}) && (cov_y_r >= {1'b0, dist_y_r});
  end

  always_comb begin
    dir_nxt    = 2'b00;
    dist_x_nxt = nx_r - pos_x_r;
    dist_y_nxt = ny_r - pos_y_r;
    if (nx_r < pos_x_r) begin
      dir_nxt[0] = 1'b1;
      dist_x_nxt = pos_x_r - nx_r;
    end
    if (ny_r < pos_y_r) begin
      dir_nxt[1] = 1'b1;
      dist_y_nxt = pos_y_r - ny_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      steps_x_r   <= RST_STEPS_X;
      steps_y_r   <= RST_STEPS_Y;
      travel_x_r  <= RST_TRAVEL_X;
      travel_y_r  <= RST_TRAVEL_Y;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      dist_x_r    <= '0;
      dist_y_r    <= '0;
      err_r       <= '0;
      cov_x_r     <= '0;
      cov_y_r     <= '0;
      pend_x_r    <= 1'b0;
      pend_y_r    <= 1'b0;
      dir_r       <= 2'b00;
      run_r       <= 1'b0;
      tick_cnt_r  <= '0;
      tick_per_r  <= 16'd1;
      pen_r       <= '0;
      out_valid_r <= 1'b0;
      axis_y_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEPS_X:  steps_x_r  <= cfg_wdata;
          CFG_STEPS_Y:  steps_y_r  <= cfg_wdata;
          CFG_TRAVEL_X: travel_x_r <= cfg_wdata;
          CFG_TRAVEL_Y: travel_y_r <= cfg_wdata;
        endcase
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (q_pop) begin
            out_valid_r <= 1'b1;
            sx_r        <= 1'b0;
            sy_r        <= 1'b0;
            done_r      <= 1'b0;
            rej_r       <= 1'b0;
            if (!q_cmd.is_tick) begin
              if (run_r) begin
                rej_r <= 1'b1;
              end else begin
                out_valid_r <= 1'b0;
                tgt_x_r     <= q_cmd.target_x;
                tgt_y_r     <= q_cmd.target_y;
                pen_r       <= q_cmd.pen;
                tick_per_r  <= q_cmd.interval;
                tick_cnt_r  <= '0;
                axis_y_r    <= 1'b0;
                st_r        <= ST_MUL;
              end
            end else if (run_r) begin
              if (!expire) begin
                tick_cnt_r <= cnt_inc[15:0];
              end else begin
                tick_cnt_r <= '0;
                if (pend_x_r || pend_y_r) begin
                  if (pend_x_r) begin
                    sx_r     <= 1'b1;
                    pend_x_r <= 1'b0;
                    pos_x_r  <= dir_r[0] ? pos_x_r - POS_BITS'(1) : pos_x_r + POS_BITS'(1);
                  end
                  if (pend_y_r) begin
                    sy_r     <= 1'b1;
                    pend_y_r <= 1'b0;
                    pos_y_r  <= dir_r[1] ? pos_y_r - POS_BITS'(1) : pos_y_r + POS_BITS'(1);
                  end
                end else if (complete) begin
                  run_r  <= 1'b0;
                  done_r <= 1'b1;
                end else begin
                  err_r <= err_sum[EW-1:0];
                  if (y_dec) begin
                    cov_y_r  <= cov_y_r + CW'(1);
                    pend_y_r <= 1'b1;
                  end
                  if (x_dec) begin
                    cov_x_r  <= cov_x_r + CW'(1);
                    pend_x_r <= 1'b1;
                  end
                end
              end
            end
          end
        end
        ST_MUL: begin
          dvd_r     <= product;
          quo_r     <= '0;
          rem_r     <= '0;
          div_cnt_r <= '0;
          st_r      <= ST_DIV;
        end
        ST_DIV: begin
          dvd_r     <= {dvd_r[PROD_W-2:0], 1'b0};
          quo_r     <= quo_nxt;
          rem_r     <= rem_nxt;
          div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
          if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
            if (axis_y_r) begin
              ny_r <= scaled;
              st_r <= ST_FIN;
            end else begin
              nx_r     <= scaled;
              axis_y_r <= 1'b1;
              st_r     <= ST_MUL;
            end
          end
        end
        ST_FIN: begin
          dir_r       <= dir_nxt;
          dist_x_r    <= dist_x_nxt;
          dist_y_r    <= dist_y_nxt;
          err_r       <= EW'($signed({3'b000, dist_x_nxt}) - $signed({3'b000, dist_y_nxt}));
          cov_x_r     <= '0;
          cov_y_r     <= '0;
          pend_x_r    <= 1'b0;
          pend_y_r    <= 1'b0;
          run_r       <= 1'b1;
          out_valid_r <= 1'b1;
          sx_r        <= 1'b0;
          sy_r        <= 1'b0;
          done_r      <= 1'b0;
          rej_r       <= 1'b0;
          st_r        <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign pos_x_w         = PROD_W'(pos_x_r);
  assign pos_y_w         = PROD_W'(pos_y_r);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.step_x   = sx_r;
  assign out_ch.step_y   = sy_r;
  assign out_ch.dir_x    = dir_r[0];
  assign out_ch.dir_y    = dir_r[1];
  assign out_ch.pen_out  = pen_r;
  assign out_ch.busy_res = run_r;
  assign out_ch.done_res = done_r;
  assign out_ch.rejected = rej_r;
  assign out_ch.pos_x    = pos_x_w[15:0];
  assign out_ch.pos_y    = pos_y_w[15:0];

  `TALS_ASSERT_IMP(a_pend_needs_run, clk, rst_n, pend_x_r || pend_y_r, run_r)
  `TALS_ASSERT_IMP(a_scale_when_idle, clk, rst_n, st_r != ST_IDLE, !run_r && !out_valid_r)
  `TALS_ASSERT_IMP(a_reject_busy, clk, rst_n, out_valid_r && rej_r, run_r)
  `TALS_ASSERT_IMP(a_start_after_fin, clk, rst_n, $rose(run_r), $past(st_r) == ST_FIN)

endmodule

// ===== src/two_axis_line_stepper.sv =====
// A tick passes the front register, queue and result register; one tick per cycle while out_ch is ready.
// A move item occupies the back end through two serial 32-step divisions, one per axis.
// Input items keep flowing into the two-entry queue while a move is being scaled.
// Reset is synchronous and active low; it clears position, line state and queue at once.
// After reset the scale registers hold their default calibration values.
module two_axis_line_stepper #(
  parameter int POS_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tals_in_if.sink                         in_ch,
  tals_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tals_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tals_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tals_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  tals_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  tals_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  tals_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (pop_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the two-axis line stepper: directed tables around random phases.
module tb;
  import tals_pkg::*;

  typedef struct packed {
    logic        step_x;
    logic        step_y;
    logic        dir_x;
    logic        dir_y;
    logic [7:0]  pen;
    logic        busy;
    logic        done;
    logic        rejected;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } report_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [15:0]          reg_val;
    cmd_t                 cmd;
    logic                 typed;
    report_t              want;
  } plan_row_t;

  localparam cmd_t TICK_CMD = '{is_tick: OP_TICK, default: '0};
  localparam int QUIET_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tals_in_if in_ch ();
  tals_out_if out_ch ();

  two_axis_line_stepper u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [15:0] steps_x = RST_STEPS_X;
  logic [15:0] steps_y = RST_STEPS_Y;
  logic [15:0] units_x = RST_TRAVEL_X;
  logic [15:0] units_y = RST_TRAVEL_Y;

  logic [15:0]        cur_x = '0;
  logic [15:0]        cur_y = '0;
  logic [16:0]        span_x = '0;
  logic [16:0]        span_y = '0;
  logic signed [18:0] err_term = '0;
  logic [16:0]        taken_x = '0;
  logic [16:0]        taken_y = '0;
  logic               owe_x = 1'b0;
  logic               owe_y = 1'b0;
  logic [1:0]         heading = '0;
  logic               moving = 1'b0;
  logic [15:0]        tick_cnt = '0;
  logic [15:0]        tick_len = 16'd1;
  logic [7:0]         pen_hold = '0;

  report_t awaited_reports[$];
  int mismatches = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int quiet = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] to_steps(logic [15:0] target, logic [15:0] steps,
                                           logic [15:0] units);
    logic [31:0] quot;
    if (units == '0) return '1;
    quot = (32'(target) * 32'(steps)) / 32'(units);
    return (quot > 32'hFFFF) ? '1 : quot[15:0];
  endfunction

  function automatic report_t advance_plotter(cmd_t c);
    report_t r;
    logic [15:0] goal_x;
    logic [15:0] goal_y;
    int e2;
    int next;
    r = '0;
    if (c.is_tick == OP_MOVE) begin
      if (moving) begin
        r.rejected = 1'b1;
      end else begin
        goal_x = to_steps(c.target_x, steps_x, units_x);
        goal_y = to_steps(c.target_y, steps_y, units_y);
        heading[0] = goal_x < cur_x;
        heading[1] = goal_y < cur_y;
        span_x = heading[0] ? cur_x - goal_x : goal_x - cur_x;
        span_y = heading[1] ? cur_y - goal_y : goal_y - cur_y;
        err_term = 19'(int'(span_x) - int'(span_y));
        taken_x = '0;
        taken_y = '0;
        owe_x = 1'b0;
        owe_y = 1'b0;
        pen_hold = c.pen;
        tick_len = (c.interval == '0) ? 16'd1 : c.interval;
        tick_cnt = '0;
        moving = 1'b1;
      end
    end else if (moving) begin
      next = int'(tick_cnt) + 1;
      if (next >= int'(tick_len)) begin
        tick_cnt = '0;
        if (owe_x || owe_y) begin
          if (owe_x) begin
            r.step_x = 1'b1;
            owe_x = 1'b0;
            cur_x = heading[0] ? cur_x - 16'd1 : cur_x + 16'd1;
          end
          if (owe_y) begin
            r.step_y = 1'b1;
            owe_y = 1'b0;
            cur_y = heading[1] ? cur_y - 16'd1 : cur_y + 16'd1;
          end
        end else if (taken_x >= span_x && taken_y >= span_y) begin
          moving = 1'b0;
          r.done = 1'b1;
        end else begin
          e2 = 2 * int'(err_term);
          if (e2 <= int'(span_x)) begin
            err_term = 19'(int'(err_term) + int'(span_x));
            taken_y++;
            owe_y = 1'b1;
          end
          if (e2 >= -int'(span_y)) begin
            err_term = 19'(int'(err_term) - int'(span_y));
            taken_x++;
            owe_x = 1'b1;
          end
        end
      end else begin
        tick_cnt = 16'(next);
      end
    end
    r.dir_x = heading[0];
    r.dir_y = heading[1];
    r.pen = pen_hold;
    r.busy = moving;
    r.pos_x = cur_x;
    r.pos_y = cur_y;
    return r;
  endfunction

  function automatic cmd_t move_to(logic [15:0] tx, logic [15:0] ty, logic [7:0] pen,
                                   logic [15:0] ivl);
    return '{is_tick: OP_MOVE, target_x: tx, target_y: ty, pen: pen, interval: ivl};
  endfunction

  function automatic cmd_t wild_move();
    return move_to(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endfunction

  // Smallest target in physical units whose scaled value is the wanted step position.
  function automatic logic [15:0] aim_units(logic [15:0] pos, logic [15:0] steps,
                                            logic [15:0] units, int delta);
    longint reach;
    longint d;
    longint t;
    reach = to_steps(16'hFFFF, steps, units);
    d = longint'(pos) + delta;
    if (d < 0) d = 0;
    if (d > reach) d = reach;
    t = (d * units + steps - 1) / steps;
    return (t > 65535) ? 16'hFFFF : 16'(t);
  endfunction

  function automatic cmd_t aimed_move();
    cmd_t c;
    c.is_tick = OP_MOVE;
    if (to_steps(16'hFFFF, steps_x, units_x) <= 64 &&
        to_steps(16'hFFFF, steps_y, units_y) <= 64) begin
      c.target_x = 16'($urandom_range(0, 65535));
      c.target_y = 16'($urandom_range(0, 65535));
    end else begin
      c.target_x = aim_units(cur_x, steps_x, units_x, int'($urandom_range(0, 12)) - 6);
      c.target_y = aim_units(cur_y, steps_y, units_y, int'($urandom_range(0, 12)) - 6);
    end
    c.pen = 8'($urandom_range(0, 255));
    c.interval = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(3, 5)) :
                                               16'($urandom_range(0, 2));
    return c;
  endfunction

  function automatic plan_row_t row_item(cmd_t c);
    return '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, cmd: c, typed: 1'b0, want: '0};
  endfunction

  function automatic plan_row_t row_item_want(cmd_t c, report_t w);
    return '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, cmd: c, typed: 1'b1, want: w};
  endfunction

  function automatic plan_row_t row_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    return '{kind: ROW_WRITE, reg_idx: idx, reg_val: val, cmd: TICK_CMD, typed: 1'b0, want: '0};
  endfunction

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEPS_X: steps_x = val;
      CFG_STEPS_Y: steps_y = val;
      CFG_TRAVEL_X: units_x = val;
      CFG_TRAVEL_Y: units_y = val;
      default: ;
    endcase
  endtask

  task automatic issue_cmd(input cmd_t c, input logic typed, input report_t want,
                           output bit counted);
    int gap;
    bit was_moving;
    report_t predicted;
    gap = 0;
    while ($urandom_range(0, 99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= c.is_tick;
    in_ch.target_x <= c.target_x;
    in_ch.target_y <= c.target_y;
    in_ch.pen_setting <= c.pen;
    in_ch.interval_ticks <= c.interval;
    do @(posedge clk); while (!in_ch.ready);
    was_moving = moving;
    predicted = advance_plotter(c);
    awaited_reports.push_back(typed ? want : predicted);
    counted = (c.is_tick == OP_TICK) ? was_moving : !was_moving;
  endtask

  task automatic walk_rows(input plan_row_t rows[$]);
    bit unused;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        issue_cmd(rows[i].cmd, rows[i].typed, rows[i].want, unused);
      end
    end
  endtask

  task automatic random_phase(input int send_pct, input int stall, input logic [15:0] sx,
                              input logic [15:0] sy, input logic [15:0] ux,
                              input logic [15:0] uy, input int quota);
    int effective;
    bit counted;
    cmd_t c;
    write_reg(CFG_STEPS_X, sx);
    write_reg(CFG_STEPS_Y, sy);
    write_reg(CFG_TRAVEL_X, ux);
    write_reg(CFG_TRAVEL_Y, uy);
    send_gap_pct = send_pct;
    stall_pct = stall;
    effective = 0;
    while (effective < quota || moving) begin
      if (moving) begin
        c = (effective < quota && $urandom_range(0, 99) < 6) ? wild_move() : TICK_CMD;
      end else if ($urandom_range(0, 99) < 8) begin
        c = TICK_CMD;
      end else begin
        c = aimed_move();
      end
      issue_cmd(c, 1'b0, '0, counted);
      if (counted) effective++;
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    report_t got;
    report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{step_x: out_ch.step_x, step_y: out_ch.step_y, dir_x: out_ch.dir_x,
              dir_y: out_ch.dir_y, pen: out_ch.pen_out, busy: out_ch.busy_res,
              done: out_ch.done_res, rejected: out_ch.rejected, pos_x: out_ch.pos_x,
              pos_y: out_ch.pos_y};
      if (awaited_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
      end else begin
        want = awaited_reports.pop_front();
        check_field("step_x", want.step_x, got.step_x);
        check_field("step_y", want.step_y, got.step_y);
        check_field("dir_x", want.dir_x, got.dir_x);
        check_field("dir_y", want.dir_y, got.dir_y);
        check_field("pen_out", want.pen, got.pen);
        check_field("busy_res", want.busy, got.busy);
        check_field("done_res", want.done, got.done);
        check_field("rejected", want.rejected, got.rejected);
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t opening[$];
    plan_row_t closing[$];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_TICK;
    in_ch.target_x <= '0;
    in_ch.target_y <= '0;
    in_ch.pen_setting <= '0;
    in_ch.interval_ticks <= '0;

    opening.push_back(row_item_want(TICK_CMD, '0));
    opening.push_back(row_item_want(move_to(16'd6, 16'd7, 8'hFF, 16'd0),
                                    '{pen: 8'hFF, busy: 1'b1, default: '0}));
    opening.push_back(row_item_want(move_to(16'hFFFF, 16'hFFFF, 8'h00, 16'hFFFF),
                                    '{pen: 8'hFF, busy: 1'b1, rejected: 1'b1, default: '0}));
    repeat (6) opening.push_back(row_item(TICK_CMD));
    opening.push_back(row_write(CFG_STEPS_X, 16'd1));
    opening.push_back(row_write(CFG_TRAVEL_X, 16'hFFFF));
    opening.push_back(row_write(CFG_STEPS_Y, 16'hFFFF));
    opening.push_back(row_write(CFG_TRAVEL_Y, 16'hFFFF));
    opening.push_back(row_item(move_to(16'hFFFF, 16'd0, 8'h5A, 16'd1)));
    repeat (5) opening.push_back(row_item(TICK_CMD));
    opening.push_back(row_item(move_to(16'hFFFF, 16'd0, 8'h00, 16'd2)));
    repeat (2) opening.push_back(row_item(TICK_CMD));

    // The zero divisor on x and the overflowing product on y both saturate, so this
    // move is long; it runs last and is only watched for its first steps.
    closing.push_back(row_write(CFG_TRAVEL_X, 16'd0));
    closing.push_back(row_write(CFG_STEPS_Y, 16'hFFFF));
    closing.push_back(row_write(CFG_TRAVEL_Y, 16'd1));
    closing.push_back(row_item(move_to(16'hC3A5, 16'd2, 8'hA5, 16'd1)));
    repeat (12) closing.push_back(row_item(TICK_CMD));
    closing.push_back(row_item(move_to(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF)));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    walk_rows(opening);
    random_phase(0, 0, RST_STEPS_X, RST_STEPS_Y, RST_TRAVEL_X, RST_TRAVEL_Y, 280);
    random_phase(72, 0, 16'd16, 16'd9, 16'hFFFF, 16'hFFFF, 280);
    random_phase(0, 72, 16'd1000, 16'd777, 16'd1000, 16'hFFFF, 280);
    random_phase(23, 23, 16'd1, 16'd1, 16'd1, 16'd1, 280);
    random_phase(0, 0, 16'hFFFF, 16'd40000, 16'hFFFF, 16'hFFFF, 280);
    walk_rows(closing);

    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
